### hw/rtl/sla_pkg.sv
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants of the semi-Lagrangian advection sampler.
// ----------------------------------------------------------------------------
package sla_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int COORD_BITS  = 6;
  localparam int ADDR_BITS   = 2 * COORD_BITS;
  localparam int SAMPLE_W    = 16;
  localparam int WORD_BITS   = 4 * SAMPLE_W;
  localparam int BASE_BITS   = 18;
  localparam int FOLD_STEPS  = BASE_BITS;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WRAP_H      = 3'd2;
  localparam logic [2:0] REG_WRAP_V      = 3'd3;
  localparam logic [2:0] REG_STEP_LENGTH = 3'd4;

  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] y1;
  } taps_t;

  typedef struct packed {
    logic [6:0] ew;
    logic [6:0] eh;
    logic       wrap_h;
    logic       wrap_v;
  } fold_cfg_t;

endpackage

### hw/rtl/sla_field_ram.sv
// ----------------------------------------------------------------------------
// sla_field_ram
// Field grid store, one 64-bit texel word per entry, registered read.
// ----------------------------------------------------------------------------
module sla_field_ram import sla_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WORD_BITS-1:0] rdata
);

  logic [WORD_BITS-1:0] mem [MAX_WIDTH*MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sla_fold.sv
// ----------------------------------------------------------------------------
// sla_fold
// Folds the base tap onto the grid: bit-serial remainder for periodic axes,
// clamping otherwise.
// ----------------------------------------------------------------------------
module sla_fold import sla_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [BASE_BITS-1:0] bx,
  input  logic signed [BASE_BITS-1:0] by,
  input  fold_cfg_t                   cfg,
  output logic                        done,
  output taps_t                       taps
);

  logic                        run_r, run_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic [BASE_BITS-1:0]        magx_r, magx_nxt, magy_r, magy_nxt;
  logic [6:0]                  remx_r, remx_nxt, remy_r, remy_nxt;
  logic signed [BASE_BITS-1:0] bx_r, by_r;
  logic                        done_r, done_nxt;
  taps_t                       taps_r, taps_nxt;
  logic [7:0]                  tx_s, ty_s;
  logic [6:0]                  rx, ry, rx1, ry1;
  logic signed [BASE_BITS:0]   bx1, by1, ewx, ehx;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    magx_nxt = magx_r;
    magy_nxt = magy_r;
    remx_nxt = remx_r;
    remy_nxt = remy_r;
    done_nxt = 1'b0;
    taps_nxt = taps_r;
    tx_s = {remx_r, magx_r[BASE_BITS-1]};
    ty_s = {remy_r, magy_r[BASE_BITS-1]};
    rx  = 7'd0;
    ry  = 7'd0;
    rx1 = 7'd0;
    ry1 = 7'd0;
    bx1 = {bx_r[BASE_BITS-1], bx_r} + 19'sd1;
    by1 = {by_r[BASE_BITS-1], by_r} + 19'sd1;
    ewx = $signed({12'd0, cfg.ew});
    ehx = $signed({12'd0, cfg.eh});
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = 5'd0;
      magx_nxt = bx[BASE_BITS-1] ? BASE_BITS'(-bx) : BASE_BITS'(bx);
      magy_nxt = by[BASE_BITS-1] ? BASE_BITS'(-by) : BASE_BITS'(by);
      remx_nxt = 7'd0;
      remy_nxt = 7'd0;
    end else if (run_r) begin
      if (cnt_r == 5'(FOLD_STEPS)) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
        rx = (bx_r[BASE_BITS-1] && remx_r != 7'd0) ? cfg.ew - remx_r : remx_r;
        ry = (by_r[BASE_BITS-1] && remy_r != 7'd0) ? cfg.eh - remy_r : remy_r;
        rx1 = (rx + 7'd1 == cfg.ew) ? 7'd0 : rx + 7'd1;
        ry1 = (ry + 7'd1 == cfg.eh) ? 7'd0 : ry + 7'd1;
        if (cfg.wrap_h) begin
          taps_nxt.x0 = rx[COORD_BITS-1:0];
          taps_nxt.x1 = rx1[COORD_BITS-1:0];
        end else begin
          taps_nxt.x0 = bx_r[BASE_BITS-1] ? '0 :
                        ({bx_r[BASE_BITS-1], bx_r} >= ewx) ? COORD_BITS'(cfg.ew - 7'd1) :
                        bx_r[COORD_BITS-1:0];
          taps_nxt.x1 = bx1[BASE_BITS] ? '0 :
                        (bx1 >= ewx) ? COORD_BITS'(cfg.ew - 7'd1) : bx1[COORD_BITS-1:0];
        end
        if (cfg.wrap_v) begin
          taps_nxt.y0 = ry[COORD_BITS-1:0];
          taps_nxt.y1 = ry1[COORD_BITS-1:0];
        end else begin
          taps_nxt.y0 = by_r[BASE_BITS-1] ? '0 :
                        ({by_r[BASE_BITS-1], by_r} >= ehx) ? COORD_BITS'(cfg.eh - 7'd1) :
                        by_r[COORD_BITS-1:0];
          taps_nxt.y1 = by1[BASE_BITS] ? '0 :
                        (by1 >= ehx) ? COORD_BITS'(cfg.eh - 7'd1) : by1[COORD_BITS-1:0];
        end
      end else begin
        cnt_nxt  = cnt_r + 5'd1;
        magx_nxt = {magx_r[BASE_BITS-2:0], 1'b0};
        magy_nxt = {magy_r[BASE_BITS-2:0], 1'b0};
        remx_nxt = (tx_s >= {1'b0, cfg.ew}) ? 7'(tx_s - {1'b0, cfg.ew}) : tx_s[6:0];
        remy_nxt = (ty_s >= {1'b0, cfg.eh}) ? 7'(ty_s - {1'b0, cfg.eh}) : ty_s[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    magx_r <= magx_nxt;
    magy_r <= magy_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
    taps_r <= taps_nxt;
    if (start) begin
      bx_r <= bx;
      by_r <= by;
    end
  end

  assign done = done_r;
  assign taps = taps_r;

endmodule

### hw/rtl/sla_lerp.sv
// ----------------------------------------------------------------------------
// sla_lerp
// Bilinear blend: reads the four taps in turn and accumulates weighted
// samples in four channel lanes.
// ----------------------------------------------------------------------------
module sla_lerp import sla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  taps_t                taps,
  input  logic [15:0]          fx,
  input  logic [15:0]          fy,
  output logic [ADDR_BITS-1:0] raddr,
  input  logic [WORD_BITS-1:0] rdata,
  output logic                 done,
  output logic [SAMPLE_W-1:0]  sample [4]
);

  logic               wt_r, issue_r, acc_en_r, done_r;
  logic [1:0]         icnt_r, acc_idx_r;
  taps_t              taps_r;
  logic [32:0]        w_r [4];
  logic [16:0]        wx0, wx1, wy0, wy1;
  logic signed [48:0] acc_r [4];
  logic signed [49:0] prod [4];

  assign wx1 = {1'b0, fx};
  assign wy1 = {1'b0, fy};
  assign wx0 = 17'h10000 - wx1;
  assign wy0 = 17'h10000 - wy1;

  always_comb begin
    case (icnt_r)
      2'd0:    raddr = {taps_r.y0, taps_r.x0};
      2'd1:    raddr = {taps_r.y0, taps_r.x1};
      2'd2:    raddr = {taps_r.y1, taps_r.x0};
      default: raddr = {taps_r.y1, taps_r.x1};
    endcase
    for (int c = 0; c < 4; c++) begin
      prod[c] = $signed(rdata[c*SAMPLE_W +: SAMPLE_W]) * $signed({1'b0, w_r[acc_idx_r]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wt_r     <= 1'b0;
      issue_r  <= 1'b0;
      acc_en_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      wt_r     <= start;
      if (wt_r) begin
        issue_r <= 1'b1;
      end else if (issue_r && icnt_r == 2'd3) begin
        issue_r <= 1'b0;
      end
      acc_en_r <= issue_r;
      done_r   <= acc_en_r && acc_idx_r == 2'd3;
    end
    if (start) begin
      taps_r <= taps;
      w_r[0] <= 33'(wx0 * wy0);
      w_r[1] <= 33'(wx1 * wy0);
      w_r[2] <= 33'(wx0 * wy1);
      w_r[3] <= 33'(wx1 * wy1);
    end
    if (wt_r) begin
      icnt_r <= 2'd0;
      for (int c = 0; c < 4; c++) begin
        acc_r[c] <= 49'sd2147483648;
      end
    end else if (issue_r) begin
      icnt_r <= icnt_r + 2'd1;
    end
    acc_idx_r <= icnt_r;
    if (acc_en_r) begin
      for (int c = 0; c < 4; c++) begin
        acc_r[c] <= acc_r[c] + prod[c][48:0];
      end
    end
  end

  assign done = done_r;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sample[c] = acc_r[c][47:32];
    end
  end

endmodule

### hw/rtl/semi_lagrangian_advect_sampler.sv
// ----------------------------------------------------------------------------
// semi_lagrangian_advect_sampler
// Four-channel field grid with back-traced bilinear advection queries.
// ----------------------------------------------------------------------------
// Channel   Handshake                    Payload
// input     start / busy                 in_kind, in_texel_*, in_value_*, in_vel_*, in_row_metric
// result    out_valid (one-cycle strobe)  out_sample_0..3
// config    psel/penable/pwrite/pready   paddr, pwdata, prdata
//
// A write word is stored at its accept edge and busy stays low.
// A query holds busy through two multiply states, one position state, the fold
// unit (18 bit-serial remainder steps, a tap step and the hand-over), then the
// four reads of the single grid port and their accumulation. The result is strobed
// in the last busy cycle.
// Synchronous active-low reset clears the control state; the grid is not cleared.
// The receiver cannot stall: out_valid is high for one cycle per query.
module semi_lagrangian_advect_sampler import sla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [5:0]  in_texel_x,
  input  logic [5:0]  in_texel_y,
  input  logic [15:0] in_value_0,
  input  logic [15:0] in_value_1,
  input  logic [15:0] in_value_2,
  input  logic [15:0] in_value_3,
  input  logic [15:0] in_vel_x,
  input  logic [15:0] in_vel_y,
  input  logic [15:0] in_row_metric,
  output logic        out_valid,
  output logic [15:0] out_sample_0,
  output logic [15:0] out_sample_1,
  output logic [15:0] out_sample_2,
  output logic [15:0] out_sample_3,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M1   = 3'd1;
  localparam logic [2:0] S_M2   = 3'd2;
  localparam logic [2:0] S_POS  = 3'd3;
  localparam logic [2:0] S_FOLD = 3'd4;
  localparam logic [2:0] S_LERP = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  grid_width_r, grid_height_r;
  logic        wrap_h_r, wrap_v_r;
  logic [15:0] step_r;

  logic [5:0]         tx_r, ty_r;
  logic [15:0]        vx_r, vy_r, metric_r;
  logic signed [32:0] pxm_r, pym_r;
  logic signed [49:0] dxp_r, dyp_r;
  logic [15:0]        fx_r, fy_r;

  logic        accept, cfg_we, fold_start, fold_done, lerp_done;
  fold_cfg_t   fcfg;
  taps_t       taps;
  logic [ADDR_BITS-1:0] raddr;
  logic [WORD_BITS-1:0] rdata;
  logic [SAMPLE_W-1:0]  sample [4];

  logic signed [49:0] dxr, dyr;
  logic signed [35:0] px, py, pxs, pys;
  logic signed [33:0] ox, oy;

  assign accept = start && !busy;
  assign busy   = state_r != S_IDLE;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= 7'd64;
      grid_height_r <= 7'd64;
      wrap_h_r      <= 1'b0;
      wrap_v_r      <= 1'b0;
      step_r        <= 16'd4096;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_GRID_WIDTH:  grid_width_r  <= pwdata[6:0];
        REG_GRID_HEIGHT: grid_height_r <= pwdata[6:0];
        REG_WRAP_H:      wrap_h_r      <= pwdata[0];
        REG_WRAP_V:      wrap_v_r      <= pwdata[0];
        REG_STEP_LENGTH: step_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GRID_WIDTH:  prdata = {25'd0, grid_width_r};
      REG_GRID_HEIGHT: prdata = {25'd0, grid_height_r};
      REG_WRAP_H:      prdata = {31'd0, wrap_h_r};
      REG_WRAP_V:      prdata = {31'd0, wrap_v_r};
      REG_STEP_LENGTH: prdata = {16'd0, step_r};
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    fcfg.ew = (grid_width_r == 7'd0) ? 7'd1 :
              (grid_width_r > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : grid_width_r;
    fcfg.eh = (grid_height_r == 7'd0) ? 7'd1 :
              (grid_height_r > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height_r;
    fcfg.wrap_h = wrap_h_r;
    fcfg.wrap_v = wrap_v_r;
  end

  always_comb begin
    dxr = dxp_r + 50'sd32768;
    dyr = dyp_r + 50'sd32768;
    px  = $signed({14'd0, tx_r, 16'h8000}) - 36'($signed(dxr[49:16]));
    py  = $signed({14'd0, ty_r, 16'h8000}) - 36'($signed(dyr[49:16]));
    pxs = (px > 36'sd2147483648) ? 36'sd2147483648 :
          (px < -36'sd2147483648) ? -36'sd2147483648 : px;
    pys = (py > 36'sd2147483648) ? 36'sd2147483648 :
          (py < -36'sd2147483648) ? -36'sd2147483648 : py;
    ox  = 34'(pxs - 36'sd32768);
    oy  = 34'(pys - 36'sd32768);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept && in_kind) state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_POS;
      S_POS:  state_nxt = S_FOLD;
      S_FOLD: if (fold_done) state_nxt = S_LERP;
      S_LERP: if (lerp_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign fold_start = state_r == S_POS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept) begin
      tx_r     <= in_texel_x;
      ty_r     <= in_texel_y;
      vx_r     <= in_vel_x;
      vy_r     <= in_vel_y;
      metric_r <= in_row_metric;
    end
    pxm_r <= 33'($signed(vx_r) * $signed({1'b0, metric_r}));
    pym_r <= 33'($signed(vy_r) * $signed({1'b0, step_r}));
    dxp_r <= 50'(pxm_r * $signed({1'b0, step_r}));
    dyp_r <= {{5{pym_r[32]}}, pym_r, 12'd0};
    if (fold_start) begin
      fx_r <= ox[15:0];
      fy_r <= oy[15:0];
    end
  end

  sla_field_ram u_ram (
    .clk   (clk),
    .we    (accept && !in_kind),
    .waddr ({in_texel_y, in_texel_x}),
    .wdata ({in_value_3, in_value_2, in_value_1, in_value_0}),
    .raddr (raddr),
    .rdata (rdata)
  );

  sla_fold u_fold (
    .clk   (clk),
    .rst_n (rst_n),
    .start (fold_start),
    .bx    (ox[33:16]),
    .by    (oy[33:16]),
    .cfg   (fcfg),
    .done  (fold_done),
    .taps  (taps)
  );

  sla_lerp u_lerp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (fold_done),
    .taps   (taps),
    .fx     (fx_r),
    .fy     (fy_r),
    .raddr  (raddr),
    .rdata  (rdata),
    .done   (lerp_done),
    .sample (sample)
  );

  assign out_valid    = lerp_done;
  assign out_sample_0 = sample[0];
  assign out_sample_1 = sample[1];
  assign out_sample_2 = sample[2];
  assign out_sample_3 = sample[3];

endmodule

### hw/rtl/sla_checker.sv
// ----------------------------------------------------------------------------
// sla_checker
// Port-level checks of the advection sampler, bound to the top level.
// ----------------------------------------------------------------------------
module sla_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_kind,
  input logic out_valid
);

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_kind |=> !busy) else $error("write word left busy high");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind |=> busy) else $error("query word did not raise busy");

  a_result_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result word outside a query");

  a_result_ends_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid) else $error("query did not end after its result");

endmodule

bind semi_lagrangian_advect_sampler sla_checker u_sla_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_kind   (in_kind),
  .out_valid (out_valid)
);
